[design/assert_macros.svh]
// Assertion macros shared by the identity registry RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication into the next cycle outside reset.
`define ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[design/idreg_pkg.sv]
// Package for the identity registry: sizes, codes, payload and entry types.
// Used by the top level and idreg_match; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package idreg_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int NODE_W = 7;
  localparam logic [7:0] MAX_NODE = 8'd127;

  typedef enum logic [0:0] {
    OP_LOOKUP   = 1'b0,
    OP_REGISTER = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_INVALID   = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_CONFLICT  = 3'd3,
    STATUS_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] vendor_id;
    logic [31:0] product_code;
    logic [31:0] revision_number;
    logic [31:0] serial_number;
    logic [7:0]  node_id;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [NODE_W-1:0] found_node_id;
  } rsp_t;

  typedef struct packed {
    logic [127:0]      identity;
    logic [NODE_W-1:0] node;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic id_hit;
    logic node_hit;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[design/identity_node_id_registry_top.sv]
// Top level of the identity registry: sequencer, entry memory and result register.
// Depends on idreg_pkg, idreg_ram, idreg_match and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// The registry maps 128-bit device identities to node numbers 1 to 127, one to one, for up
// to 16 entries. Each request walks the stored entries one per cycle through a single
// comparator fed by the entry memory's read port; a lookup or conflict ends the walk at
// the matching entry, and an invalid node number ends it without a compare. A stalled
// earlier result holds a finished request in its done state until the result register
// is free. The request channel stalls for the whole walk and the done state; a finished
// result waits in its own register, so a new request is taken while the previous result
// is still stalled.
module identity_node_id_registry_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire idreg_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output idreg_pkg::rsp_t      rsp
);
  import idreg_pkg::*;

  `include "assert_macros.svh"

  state_t            state, state_next;
  req_t              req_q;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rd_cnt, rd_cnt_next;
  logic              pend, pend_next;
  logic              hit, hit_next;
  logic              conflict, conflict_next;
  logic              present, present_next;
  logic [NODE_W-1:0] found, found_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              ram_we;
  entry_t            wr_entry;
  entry_t            rd_entry;
  match_t            m;
  logic [127:0]      key_identity;
  logic              is_lookup;
  logic              invalid_node;
  logic              stop_now;
  logic              walk_end;
  logic              rsp_free;
  logic              append;
  rsp_t              result;

  assign key_identity = {req_q.vendor_id, req_q.product_code,
                         req_q.revision_number, req_q.serial_number};
  assign is_lookup    = (req_q.op == OP_LOOKUP);
  assign invalid_node = !is_lookup && ((req_q.node_id == 8'd0) || (req_q.node_id > MAX_NODE));
  assign stop_now     = is_lookup ? m.id_hit : (m.id_hit != m.node_hit);
  assign walk_end     = invalid_node || (pend && stop_now) || (!pend && (rd_cnt == count));
  assign rsp_free     = !rsp_valid || !rsp_stall;
  assign req_stall    = (state != ST_IDLE);

  assign wr_entry.identity = key_identity;
  assign wr_entry.node     = req_q.node_id[NODE_W-1:0];

  idreg_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDX_W-1:0]),
    .wdata(wr_entry),
    .raddr(rd_cnt[IDX_W-1:0]),
    .rdata(rd_entry)
  );

  idreg_match u_match (
    .entry       (rd_entry),
    .key_identity(key_identity),
    .key_node    (req_q.node_id),
    .result      (m)
  );

  always_comb begin
    append = 1'b0;
    result.found_node_id = '0;
    if (is_lookup) begin
      result.status = hit ? STATUS_OK : STATUS_NOT_FOUND;
      result.found_node_id = hit ? found : '0;
    end else if (invalid_node) begin
      result.status = STATUS_INVALID;
    end else if (conflict) begin
      result.status = STATUS_CONFLICT;
    end else if (present) begin
      result.status = STATUS_OK;
    end else if (count >= CNT_W'(ENTRIES)) begin
      result.status = STATUS_FULL;
    end else begin
      result.status = STATUS_OK;
      append = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_cnt_next    = rd_cnt;
    pend_next      = 1'b0;
    hit_next       = hit;
    conflict_next  = conflict;
    present_next   = present;
    found_next     = found;
    count_next     = count;
    ram_we         = 1'b0;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    case (state)
      ST_IDLE: begin
        rd_cnt_next   = '0;
        hit_next      = 1'b0;
        conflict_next = 1'b0;
        present_next  = 1'b0;
        found_next    = '0;
      end
      ST_WALK: begin
        if (rd_cnt < count) begin
          rd_cnt_next = rd_cnt + 1'b1;
          pend_next   = 1'b1;
        end
        if (pend) begin
          if (is_lookup) begin
            if (m.id_hit) begin
              hit_next   = 1'b1;
              found_next = rd_entry.node;
            end
          end else begin
            if (m.id_hit != m.node_hit) begin
              conflict_next = 1'b1;
            end
            if (m.id_hit) begin
              present_next = 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        if (rsp_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = result;
          if (append) begin
            ram_we     = 1'b1;
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_cnt    <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      conflict  <= 1'b0;
      present   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rd_cnt    <= rd_cnt_next;
      pend      <= pend_next;
      hit       <= hit_next;
      conflict  <= conflict_next;
      present   <= present_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    found <= found_next;
    rsp   <= rsp_next;
    if (state == ST_IDLE && req_valid) begin
      req_q <= req;
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst, (count <= CNT_W'(ENTRIES)), "entry count above capacity")
  `ASSERT_NEXT(a_append_count, clk, rst, ram_we, (count == $past(count) + 1'b1), "missed count step")
  `ASSERT_NEXT(a_done_result, clk, rst, (state == ST_DONE && rsp_free), rsp_valid, "no result")
  `ASSERT_CLK(a_hit_conflict, clk, rst, !(hit && conflict), "lookup hit and conflict both set")

endmodule

`default_nettype wire

[design/idreg_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the table entries; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module idreg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/idreg_match.sv]
// Shared compare unit: matches one stored entry against the request key.
// Depends on idreg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idreg_match (
  input  wire idreg_pkg::entry_t entry,
  input  wire logic [127:0]      key_identity,
  input  wire logic [7:0]        key_node,
  output idreg_pkg::match_t      result
);
  import idreg_pkg::*;

  always_comb begin
    result.id_hit   = (entry.identity == key_identity);
    result.node_hit = ({1'b0, entry.node} == key_node);
  end

endmodule

`default_nettype wire
